@@ hdl/fast_inverse_square_root_unit_defines.svh @@
// assertion macros for the inverse square root unit
`ifndef FAST_INVERSE_SQUARE_ROOT_UNIT_DEFINES_SVH
`define FAST_INVERSE_SQUARE_ROOT_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define FISR_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// implication after a fixed number of cycles
`define FISR_ASSERT_DELAY(lbl, ante, n, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##(n) (cons)) \
    else $error("assertion failed");

`endif

@@ hdl/fisr_pkg.sv @@
package fisr_pkg;

  localparam logic [31:0] MAGIC     = 32'h5F3759DF;
  localparam logic [31:0] HALF_F    = 32'h3F000000;
  localparam logic [31:0] THREE_H_F = 32'h3FC00000;
  localparam logic [31:0] QNAN      = 32'h7FC00000;

  localparam int NOPS = 10;

  typedef enum logic [2:0] {
    OP_HALF,
    OP_HY,
    OP_TY,
    OP_SUB,
    OP_YT,
    OP_SQ
  } op_t;

  // h = v/2, then two refinement steps, then the optional scale by v
  localparam op_t OP_SEQ [NOPS] = '{
    OP_HALF, OP_HY, OP_TY, OP_SUB, OP_YT, OP_HY, OP_TY, OP_SUB, OP_YT, OP_SQ
  };

  typedef struct packed {
    logic        mode;
    logic [31:0] v;
    logic [31:0] h;
    logic [31:0] y;
    logic [31:0] t;
  } ctx_t;

  typedef struct packed {
    logic               sign;
    logic [47:0]        p;
    logic signed [10:0] e;
    logic               nan;
    logic               inf;
    logic               zero;
  } mul_mid_t;

  typedef struct packed {
    logic        sign;
    logic        zsign;
    logic [27:0] s;
    logic [7:0]  e;
    logic        nan;
    logic        inf;
    logic        isign;
  } add_mid_t;

  function automatic logic [4:0] lzc24(logic [23:0] m);
    logic [4:0] lz;
    lz = 5'd24;
    for (int i = 0; i < 24; i++) begin
      if (m[i]) lz = 5'(23 - i);
    end
    return lz;
  endfunction

  function automatic logic [4:0] lzc28(logic [27:0] m);
    logic [4:0] lz;
    lz = 5'd28;
    for (int i = 0; i < 28; i++) begin
      if (m[i]) lz = 5'(27 - i);
    end
    return lz;
  endfunction

  // operands normalized first so the product lands in [2^46, 2^48)
  function automatic mul_mid_t mul_a(logic [31:0] a, logic [31:0] b);
    mul_mid_t           r;
    logic [23:0]        ma, mb;
    logic [4:0]         lza, lzb;
    logic signed [10:0] xa, xb;
    logic               infa, infb, zra, zrb, nana, nanb;
    infa = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    infb = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    nana = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    nanb = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    zra  = (a[30:0] == 31'd0);
    zrb  = (b[30:0] == 31'd0);
    ma   = {a[30:23] != 8'd0, a[22:0]};
    mb   = {b[30:23] != 8'd0, b[22:0]};
    lza  = lzc24(ma);
    lzb  = lzc24(mb);
    xa   = $signed({3'b0, (a[30:23] == 8'd0) ? 8'd1 : a[30:23]}) - $signed({6'b0, lza});
    xb   = $signed({3'b0, (b[30:23] == 8'd0) ? 8'd1 : b[30:23]}) - $signed({6'b0, lzb});
    ma   = ma << lza;
    mb   = mb << lzb;
    r.sign = a[31] ^ b[31];
    r.p    = {24'd0, ma} * {24'd0, mb};
    r.e    = xa + xb - 11'sd127;
    r.nan  = nana || nanb || (infa && zrb) || (zra && infb);
    r.inf  = infa || infb;
    r.zero = zra || zrb;
    return r;
  endfunction

  function automatic logic [31:0] mul_b(mul_mid_t d);
    logic [47:0]        m, sft, mask;
    logic signed [10:0] e, dd;
    logic [5:0]         sh;
    logic [7:0]         ebase;
    logic               g, st, inc;
    logic [30:0]        field;
    logic [31:0]        r;
    if (d.p[47]) begin
      m = d.p;
      e = d.e + 11'sd1;
    end else begin
      m = d.p << 1;
      e = d.e;
    end
    dd = 11'sd1 - e;
    if (e >= 11'sd1) begin
      sh    = 6'd0;
      ebase = e[7:0];
    end else begin
      sh    = (dd > 11'sd48) ? 6'd48 : dd[5:0];
      ebase = 8'd0;
    end
    sft   = m >> sh;
    mask  = (48'd1 << sh) - 48'd1;
    g     = sft[23];
    st    = (|sft[22:0]) | (|(m & mask));
    inc   = g & (st | sft[24]);
    field = {ebase, sft[46:24]} + 31'(inc);
    if (d.nan) r = QNAN;
    else if (d.inf) r = {d.sign, 8'hFF, 23'd0};
    else if (d.zero) r = {d.sign, 31'd0};
    else if (e >= 11'sd255) r = {d.sign, 8'hFF, 23'd0};
    else r = {d.sign, field};
    return r;
  endfunction

  function automatic add_mid_t add_a(logic [31:0] a, logic [31:0] b);
    add_mid_t    r;
    logic [7:0]  xa, xb, xbig, xsml, dif;
    logic [23:0] ma, mb, mbig, msml;
    logic [26:0] ext, aligned, mask;
    logic        sbig, sub, swap, lost;
    logic        infa, infb, nana, nanb;
    infa = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    infb = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    nana = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    nanb = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    ma   = {a[30:23] != 8'd0, a[22:0]};
    mb   = {b[30:23] != 8'd0, b[22:0]};
    xa   = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    xb   = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    swap = {xb, mb} > {xa, ma};
    xbig = swap ? xb : xa;
    xsml = swap ? xa : xb;
    mbig = swap ? mb : ma;
    msml = swap ? ma : mb;
    sbig = swap ? b[31] : a[31];
    sub  = a[31] ^ b[31];
    dif  = xbig - xsml;
    ext  = {msml, 3'b0};
    mask = (27'd1 << dif) - 27'd1;
    if (dif >= 8'd27) begin
      aligned = 27'd0;
      lost    = |msml;
    end else begin
      aligned = ext >> dif;
      lost    = |(ext & mask);
    end
    aligned[0] = aligned[0] | lost;
    r.s     = sub ? ({1'b0, mbig, 3'b0} - {1'b0, aligned})
                  : ({1'b0, mbig, 3'b0} + {1'b0, aligned});
    r.sign  = sbig;
    r.zsign = sub ? 1'b0 : sbig;
    r.e     = xbig;
    r.nan   = nana || nanb || (infa && infb && sub);
    r.inf   = infa || infb;
    r.isign = infa ? a[31] : b[31];
    return r;
  endfunction

  function automatic logic [31:0] add_b(add_mid_t d);
    logic [27:0] n;
    logic [8:0]  e;
    logic [4:0]  lz;
    logic [7:0]  lim, amt, ebase;
    logic        g, st, inc;
    logic [30:0] field;
    logic [31:0] r;
    lz  = lzc28(d.s) - 5'd1;
    lim = d.e - 8'd1;
    amt = ({3'b0, lz} > lim) ? lim : {3'b0, lz};
    if (d.s[27]) begin
      n    = {1'b0, d.s[27:1]};
      n[0] = n[0] | d.s[0];
      e    = {1'b0, d.e} + 9'd1;
    end else begin
      n = d.s << amt;
      e = {1'b0, d.e} - {1'b0, amt};
    end
    ebase = n[26] ? e[7:0] : 8'd0;
    g     = n[2];
    st    = n[1] | n[0];
    inc   = g & (st | n[3]);
    field = {ebase, n[25:3]} + 31'(inc);
    if (d.nan) r = QNAN;
    else if (d.inf) r = {d.isign, 8'hFF, 23'd0};
    else if (d.s == 28'd0) r = {d.zsign, 31'd0};
    else if (e >= 9'd255) r = {d.sign, 8'hFF, 23'd0};
    else r = {d.sign, field};
    return r;
  endfunction

endpackage

@@ hdl/fast_inverse_square_root_unit.sv @@
// channel  | ports                      | transfer
// ---------+----------------------------+-----------------------------
// input    | start, busy, mode,         | start high, busy low at edge
//          | value_bits                 |
// result   | done, result_bits          | done high for one cycle
//
// the pipeline has one entry register, then two register stages for each
// of the ten float operations (multiply or add, then normalize and round).
// one item may enter every cycle; busy is always low.
// rst is synchronous and clears the valid bits only; data registers float.
// the receiver cannot stall, so done simply follows the valid bit of the last stage.
`include "fast_inverse_square_root_unit_defines.svh"

module fast_inverse_square_root_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        mode,
  input  logic [31:0] value_bits,
  output logic        done,
  output logic [31:0] result_bits
);

  localparam int LAT = 2 * fisr_pkg::NOPS + 1;

  fisr_pkg::ctx_t cpipe [0:fisr_pkg::NOPS];
  logic           vpipe [0:fisr_pkg::NOPS];

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe[0] <= 1'b0;
    end else begin
      vpipe[0] <= start;
    end
    cpipe[0].mode <= mode;
    cpipe[0].v    <= value_bits;
    cpipe[0].h    <= 32'd0;
    // bit trick: arithmetic shift right, subtract from the magic constant
    cpipe[0].y    <= fisr_pkg::MAGIC - {value_bits[31], value_bits[31:1]};
    cpipe[0].t    <= 32'd0;
  end

  for (genvar k = 0; k < fisr_pkg::NOPS; k++) begin : g_op
    localparam fisr_pkg::op_t OP = fisr_pkg::OP_SEQ[k];

    logic [31:0]    opa, opb, res;
    fisr_pkg::ctx_t ca;
    logic           va;
    fisr_pkg::ctx_t cpipe_next;

    always_comb begin
      unique case (OP)
        fisr_pkg::OP_HALF: begin opa = cpipe[k].v; opb = fisr_pkg::HALF_F; end
        fisr_pkg::OP_HY:   begin opa = cpipe[k].h; opb = cpipe[k].y; end
        fisr_pkg::OP_TY:   begin opa = cpipe[k].t; opb = cpipe[k].y; end
        fisr_pkg::OP_SUB:  begin
          opa = fisr_pkg::THREE_H_F;
          opb = {~cpipe[k].t[31], cpipe[k].t[30:0]};
        end
        fisr_pkg::OP_YT:   begin opa = cpipe[k].y; opb = cpipe[k].t; end
        fisr_pkg::OP_SQ:   begin opa = cpipe[k].y; opb = cpipe[k].v; end
      endcase
    end

    if (OP == fisr_pkg::OP_SUB) begin : g_add
      fisr_pkg::add_mid_t mid;
      always_ff @(posedge clk) begin
        mid <= fisr_pkg::add_a(opa, opb);
      end
      assign res = fisr_pkg::add_b(mid);
    end else begin : g_mul
      fisr_pkg::mul_mid_t mid;
      always_ff @(posedge clk) begin
        mid <= fisr_pkg::mul_a(opa, opb);
      end
      assign res = fisr_pkg::mul_b(mid);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        va           <= 1'b0;
        vpipe[k + 1] <= 1'b0;
      end else begin
        va           <= vpipe[k];
        vpipe[k + 1] <= va;
      end
      ca <= cpipe[k];
    end

    always_comb begin
      cpipe_next = ca;
      unique case (OP)
        fisr_pkg::OP_HALF: cpipe_next.h = res;
        fisr_pkg::OP_HY:   cpipe_next.t = res;
        fisr_pkg::OP_TY:   cpipe_next.t = res;
        fisr_pkg::OP_SUB:  cpipe_next.t = res;
        fisr_pkg::OP_YT:   cpipe_next.y = res;
        fisr_pkg::OP_SQ:   cpipe_next.y = ca.mode ? res : ca.y;
      endcase
    end

    always_ff @(posedge clk) begin
      cpipe[k + 1] <= cpipe_next;
    end
  end

  assign done        = vpipe[fisr_pkg::NOPS];
  assign result_bits = cpipe[fisr_pkg::NOPS].y;

  `FISR_ASSERT_DELAY(a_latency, start && !busy, LAT, done)
  `FISR_ASSERT_IMPL(a_no_spurious, done, $past(start, LAT))
  `FISR_ASSERT_IMPL(a_nan_canon,
    done && (result_bits[30:23] == 8'hFF) && (result_bits[22:0] != 23'd0),
    result_bits == fisr_pkg::QNAN)

endmodule
